@@ hdl/kict_pkg.sv @@
// ----------------------------------------------------------------------------
// kict_pkg
// Shared types and codes for the key index counter table.
// ----------------------------------------------------------------------------
package kict_pkg;

    // Width of the key words, limits and indexes.
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned PID_W    = 32;
    localparam int unsigned KEY_WRDS = 4;

    // Configuration register indexes (taken from paddr[2]).
    localparam logic REG_PID_IDX = 1'b0;

    typedef logic [KEY_WRDS-1:0][WORD_W-1:0] key_t;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_QUERY   = 2'd0,
        OP_RESERVE = 2'd1,
        OP_BOUND   = 2'd2,
        OP_REMAIN  = 2'd3
    } opcode_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_FORK      = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_BOUND     = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_INSERT,
        S_EXEC,
        S_INCR,
        S_FINISH
    } state_t;

    // Write request from the sequencer to the entry store.
    typedef struct packed {
        logic              set_valid;
        logic              key_we;
        logic              limit_we;
        logic              index_we;
        key_t              key;
        logic [WORD_W-1:0] limit;
        logic [WORD_W-1:0] index;
    } store_wr_t;

endpackage

@@ hdl/kict_alu.sv @@
// ----------------------------------------------------------------------------
// kict_alu
// Shared 64-bit add/subtract unit with carry out, used for the bound and
// limit compares and the index update of the sequencer.
// ----------------------------------------------------------------------------
module kict_alu
    import kict_pkg::*;
(
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    input  logic              sub,
    output logic [WORD_W-1:0] result,
    output logic              carry
);

    logic [WORD_W:0] sum;
    logic [WORD_W-1:0] b_op;

    // In subtract mode the carry out is high when a >= b.
    assign b_op = sub ? ~b : b;
    assign sum  = {1'b0, a} + {1'b0, b_op} + {{WORD_W{1'b0}}, sub};
    assign result = sum[WORD_W-1:0];
    assign carry  = sum[WORD_W];

endmodule

@@ hdl/kict_store.sv @@
// ----------------------------------------------------------------------------
// kict_store
// Entry store: key, limit and index memories with a registered read port,
// one write port, and the per-entry valid bits.
// ----------------------------------------------------------------------------
module kict_store
    import kict_pkg::*;
#(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned IW      = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IW-1:0]     raddr,
    output key_t              rd_key,
    output logic [WORD_W-1:0] rd_limit,
    output logic [WORD_W-1:0] rd_index,
    input  logic [IW-1:0]     waddr,
    input  store_wr_t         wr,
    output logic [ENTRIES-1:0] entry_valid
);

    key_t              key_mem   [ENTRIES];
    logic [WORD_W-1:0] limit_mem [ENTRIES];
    logic [WORD_W-1:0] index_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    // Memory writes and registered reads.
    always_ff @(posedge aclk) begin
        if (wr.key_we) begin
            key_mem[waddr] <= wr.key;
        end
        if (wr.limit_we) begin
            limit_mem[waddr] <= wr.limit;
        end
        if (wr.index_we) begin
            index_mem[waddr] <= wr.index;
        end
        rd_key   <= key_mem[raddr];
        rd_limit <= limit_mem[raddr];
        rd_index <= index_mem[raddr];
    end

    // Valid bits are cleared by reset and set on insertion.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.set_valid) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign entry_valid = valid_reg;

endmodule

@@ hdl/kict_seq.sv @@
// ----------------------------------------------------------------------------
// kict_seq
// Request sequencer: fork check, table scan one entry per cycle, insertion,
// opcode execution on the shared adder, and the result output register.
// ----------------------------------------------------------------------------
module kict_seq
    import kict_pkg::*;
#(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned IW      = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [PID_W-1:0]   registry_pid,
    // Request transfer
    input  logic               in_valid,
    output logic               in_ready,
    input  opcode_t            in_opcode,
    input  key_t               in_key,
    input  logic [PID_W-1:0]   in_key_pid,
    input  logic [PID_W-1:0]   in_cur_pid,
    input  logic [WORD_W-1:0]  in_limit,
    input  logic [WORD_W-1:0]  in_bound,
    // Result transfer
    output logic               out_valid,
    input  logic               out_ready,
    output status_t            out_status,
    output logic [WORD_W-1:0]  out_value,
    // Entry store
    output logic [IW-1:0]      raddr,
    input  key_t               rd_key,
    input  logic [WORD_W-1:0]  rd_limit,
    input  logic [WORD_W-1:0]  rd_index,
    output logic [IW-1:0]      waddr,
    output store_wr_t          wr,
    input  logic [ENTRIES-1:0] entry_valid
);

    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    state_t            state_reg, state_next;
    opcode_t           op_reg;
    key_t              key_reg;
    logic [PID_W-1:0]  kpid_reg, cpid_reg;
    logic [WORD_W-1:0] limit_reg, bound_reg;
    logic [IW-1:0]     scan_idx_reg, scan_idx_next;
    logic              issue_done_reg, issue_done_next;
    logic              pipe_live_reg, pipe_live_next;
    logic [IW-1:0]     pipe_idx_reg;
    logic              free_found_reg, free_found_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [IW-1:0]     ent_idx_reg, ent_idx_next;
    logic [WORD_W-1:0] cur_reg, cur_next;
    logic [WORD_W-1:0] slim_reg, slim_next;
    status_t           status_reg, status_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic              fork_latch_reg, fork_latch_next;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [WORD_W-1:0] out_value_reg;

    logic [WORD_W-1:0] alu_a, alu_b, alu_res;
    logic              alu_sub, alu_carry;
    logic              accept, bound_err, fork_now, hit, miss, mismatch;
    logic              exhausted, out_load;

    // Shared adder; operands depend on the step being executed.
    kict_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .result (alu_res),
        .carry  (alu_carry)
    );

    always_comb begin
        alu_a   = limit_reg;
        alu_b   = bound_reg;
        alu_sub = 1'b1;
        if (state_reg == S_EXEC) begin
            if (op_reg == OP_BOUND) begin
                alu_a = cur_reg;
                alu_b = bound_reg;
            end else begin
                alu_a = limit_reg;
                alu_b = cur_reg;
            end
        end else if (state_reg == S_INCR) begin
            alu_a   = cur_reg;
            alu_b   = {{(WORD_W-1){1'b0}}, 1'b1};
            alu_sub = 1'b0;
        end
    end

    // Conditions used by both the state and the datapath logic.
    assign accept    = in_valid && in_ready;
    assign bound_err = (op_reg == OP_BOUND) && !alu_carry;
    assign fork_now  = fork_latch_reg ||
                       ((cpid_reg != '0) &&
                        (((registry_pid != '0) && (registry_pid != cpid_reg)) ||
                         ((kpid_reg != '0) && (kpid_reg != cpid_reg))));
    assign hit       = pipe_live_reg && entry_valid[pipe_idx_reg] && (rd_key == key_reg);
    assign miss      = pipe_live_reg && !hit && (pipe_idx_reg == LAST_IDX);
    assign mismatch  = slim_reg != limit_reg;
    assign exhausted = !alu_carry || (alu_res == '0);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign in_ready  = state_reg == S_IDLE;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (bound_err || fork_now) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    state_next = S_EXEC;
                end else if (miss) begin
                    state_next = free_found_reg ? S_INSERT : S_FINISH;
                end
            end
            S_INSERT: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (!mismatch && (op_reg == OP_RESERVE) && !exhausted) begin
                    state_next = S_INCR;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_INCR: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and store control for each step.
    always_comb begin
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        pipe_live_next  = 1'b0;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ent_idx_next    = ent_idx_reg;
        cur_next        = cur_reg;
        slim_next       = slim_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        fork_latch_next = fork_latch_reg;
        raddr           = scan_idx_reg;
        waddr           = ent_idx_reg;
        wr              = '0;
        wr.key          = key_reg;
        wr.limit        = limit_reg;
        wr.index        = '0;
        unique case (state_reg)
            S_IDLE: begin
            end
            S_CHECK: begin
                status_next     = ST_OK;
                value_next      = '0;
                scan_idx_next   = '0;
                issue_done_next = 1'b0;
                free_found_next = 1'b0;
                if (bound_err) begin
                    status_next = ST_BOUND;
                end else if (fork_now) begin
                    status_next     = ST_FORK;
                    fork_latch_next = 1'b1;
                end
            end
            S_SCAN: begin
                // Issue side: one read per cycle and the lowest free entry.
                if (!issue_done_reg) begin
                    pipe_live_next = 1'b1;
                    if (!entry_valid[scan_idx_reg] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_idx_reg;
                    end
                    if (scan_idx_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                // Compare side: read data of the entry issued last cycle.
                if (hit) begin
                    ent_idx_next = pipe_idx_reg;
                    cur_next     = rd_index;
                    slim_next    = rd_limit;
                end else if (miss && !free_found_reg) begin
                    status_next = ST_FULL;
                end
            end
            S_INSERT: begin
                waddr        = free_idx_reg;
                wr.set_valid = 1'b1;
                wr.key_we    = 1'b1;
                wr.limit_we  = 1'b1;
                wr.index_we  = 1'b1;
                ent_idx_next = free_idx_reg;
                cur_next     = '0;
                slim_next    = limit_reg;
            end
            S_EXEC: begin
                if (mismatch) begin
                    status_next = ST_MISMATCH;
                end else begin
                    case (op_reg)
                        OP_QUERY: begin
                            value_next = cur_reg;
                        end
                        OP_RESERVE: begin
                            if (exhausted) begin
                                status_next = ST_EXHAUSTED;
                            end else begin
                                value_next = cur_reg;
                            end
                        end
                        OP_BOUND: begin
                            // Borrow means the bound lies above the index.
                            if (!alu_carry) begin
                                wr.index_we = 1'b1;
                                wr.index    = bound_reg;
                            end
                        end
                        default: begin
                            value_next = alu_carry ? alu_res : '0;
                        end
                    endcase
                end
            end
            S_INCR: begin
                wr.index_we = 1'b1;
                wr.index    = alu_res;
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fork_latch_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pipe_live_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fork_latch_reg <= fork_latch_next;
            pipe_live_reg  <= pipe_live_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= in_opcode;
            key_reg   <= in_key;
            kpid_reg  <= in_key_pid;
            cpid_reg  <= in_cur_pid;
            limit_reg <= in_limit;
            bound_reg <= in_bound;
        end
        scan_idx_reg   <= scan_idx_next;
        issue_done_reg <= issue_done_next;
        pipe_idx_reg   <= scan_idx_reg;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        ent_idx_reg    <= ent_idx_next;
        cur_reg        <= cur_next;
        slim_reg       <= slim_next;
        status_reg     <= status_next;
        value_reg      <= value_next;
        if (out_load) begin
            out_status_reg <= status_reg;
            out_value_reg  <= value_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;

endmodule

@@ hdl/key_index_counter_table.sv @@
// ----------------------------------------------------------------------------
// key_index_counter_table
// Table of one-time-signature index counters keyed by 256-bit identifiers.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ stream channel, one per transfer, and each gives
// exactly one result transfer on the m_ channel, in request order.
// The APB port holds the registry process identity at address 0; write it
// only while the block is idle.
// Operation: a request is first checked for a bound error or a fork, then
// scanned against the table one entry per cycle through the registered read
// port of the entry store, followed by an optional insertion, one execution
// step on the shared adder and, for a reservation that succeeds, one
// increment step. An unknown key with the table full ends after the scan.
// A bound error or a fork skips the scan and the execution step.
// s_tready rises in the cycle after the result is loaded, so a new request
// is not taken before the last result is loaded into the result register.
// The result register lets the next request be taken while a result waits;
// if the receiver stalls, a second finished result waits inside the block.
// Reset clears the valid bits, the fork latch and the registry process
// identity register; the key, limit and index memories are not cleared and
// need no clearing pass.
// ----------------------------------------------------------------------------
module key_index_counter_table
    import kict_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // opcode[1:0], key_word_0[65:2], key_word_1[129:66], key_word_2[193:130],
    // key_word_3[257:194], key_process_id[289:258],
    // present_process_id[321:290], operation_limit[385:322],
    // lower_bound[449:386], zero padding[455:450]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [455:0] s_tdata,
    // status[2:0], value[66:3], zero padding[71:67]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [PID_W-1:0]  registry_pid_reg;
    key_t              in_key;
    status_t           out_status;
    logic [WORD_W-1:0] out_value;
    logic [IW-1:0]     raddr, waddr;
    key_t              rd_key;
    logic [WORD_W-1:0] rd_limit, rd_index;
    store_wr_t         wr;
    logic [TABLE_ENTRIES-1:0] entry_valid;

    // Registry process identity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            registry_pid_reg <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_PID_IDX)) begin
            registry_pid_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PID_IDX) ? registry_pid_reg : '0;

    // Unpack the key words of the request.
    assign in_key[0] = s_tdata[65:2];
    assign in_key[1] = s_tdata[129:66];
    assign in_key[2] = s_tdata[193:130];
    assign in_key[3] = s_tdata[257:194];

    kict_seq #(
        .ENTRIES (TABLE_ENTRIES),
        .IW      (IW)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .registry_pid (registry_pid_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_opcode    (opcode_t'(s_tdata[1:0])),
        .in_key       (in_key),
        .in_key_pid   (s_tdata[289:258]),
        .in_cur_pid   (s_tdata[321:290]),
        .in_limit     (s_tdata[385:322]),
        .in_bound     (s_tdata[449:386]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_value    (out_value),
        .raddr        (raddr),
        .rd_key       (rd_key),
        .rd_limit     (rd_limit),
        .rd_index     (rd_index),
        .waddr        (waddr),
        .wr           (wr),
        .entry_valid  (entry_valid)
    );

    kict_store #(
        .ENTRIES (TABLE_ENTRIES),
        .IW      (IW)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .raddr       (raddr),
        .rd_key      (rd_key),
        .rd_limit    (rd_limit),
        .rd_index    (rd_index),
        .waddr       (waddr),
        .wr          (wr),
        .entry_valid (entry_valid)
    );

    // Pack the result transfer.
    assign m_tdata = {5'b0, out_value, out_status};

endmodule
